// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers, sampled on the rising edge of clk and
// held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when trig holds, prop must hold at the same edge
`define ASSERT_IMPLY(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) else $error(msg);

`endif

// ----- rtl/pidc_pkg.sv -----
package pidc_pkg;

  localparam int unsigned GAIN_W = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ILIM_W = 23;
  localparam int unsigned DLIM_W = 17;
  localparam int unsigned OLIM_W = 15;
  localparam int unsigned CFG_DATA_W = 23;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam int unsigned ERR_W = SAMPLE_W + 1;
  localparam int unsigned INT_W = ILIM_W + 1;
  localparam int unsigned DIFF_W = DLIM_W + 1;
  localparam int unsigned TP_W = GAIN_W + ERR_W - 8;
  localparam int unsigned TI_W = GAIN_W + INT_W - 8;
  localparam int unsigned TD_W = GAIN_W + DIFF_W - 8;
  localparam int unsigned SUM_W = TI_W + 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_ILIM = 3'd3,
    REG_DLIM = 3'd4,
    REG_OLIM = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [ILIM_W-1:0]        ilim;
    logic [DLIM_W-1:0]        dlim;
    logic [OLIM_W-1:0]        olim;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [INT_W-1:0]  integ;
    logic signed [DIFF_W-1:0] diff;
  } front_t;

  typedef struct packed {
    logic signed [TP_W-1:0] tp;
    logic signed [TI_W-1:0] ti;
    logic signed [TD_W-1:0] td;
  } terms_t;

endpackage

// ----- rtl/pidc_cfg.sv -----
module pidc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pidc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pidc_pkg::cfg_t                     cfg
);
  import pidc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp   <= GAIN_W'(256);
      cfg.ki   <= '0;
      cfg.kd   <= '0;
      cfg.ilim <= '1;
      cfg.dlim <= '1;
      cfg.olim <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KP:   cfg.kp   <= cfg_data[GAIN_W-1:0];
        REG_KI:   cfg.ki   <= cfg_data[GAIN_W-1:0];
        REG_KD:   cfg.kd   <= cfg_data[GAIN_W-1:0];
        REG_ILIM: cfg.ilim <= cfg_data[ILIM_W-1:0];
        REG_DLIM: cfg.dlim <= cfg_data[DLIM_W-1:0];
        REG_OLIM: cfg.olim <= cfg_data[OLIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pidc_front.sv -----
module pidc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pidc_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pidc_pkg::SAMPLE_W-1:0] setpoint,
  input  logic signed [pidc_pkg::SAMPLE_W-1:0] measured_value,
  output logic                                 s1_valid,
  input  logic                                 s1_ready,
  output pidc_pkg::front_t                     s1_data
);
  import pidc_pkg::*;

  logic signed [INT_W-1:0]  error_integral;
  logic signed [ERR_W-1:0]  previous_error;

  logic signed [ERR_W-1:0]  err;
  logic signed [INT_W:0]    isum;
  logic signed [INT_W:0]    ilim_s;
  logic signed [INT_W-1:0]  error_integral_next;
  logic signed [DIFF_W-1:0] dsum;
  logic signed [DIFF_W-1:0] dlim_s;
  logic signed [DIFF_W-1:0] diff;
  logic                     take;

  assign in_ready = !s1_valid || s1_ready;
  assign take = in_valid && in_ready;

  assign err = ERR_W'(setpoint) - ERR_W'(measured_value);

  // integral with anti-windup clamp
  assign isum = (INT_W+1)'(error_integral) + (INT_W+1)'(err);
  assign ilim_s = $signed({2'b00, cfg.ilim});
  always_comb begin
    if (isum > ilim_s) begin
      error_integral_next = INT_W'(ilim_s);
    end else if (isum < -ilim_s) begin
      error_integral_next = INT_W'(-ilim_s);
    end else begin
      error_integral_next = INT_W'(isum);
    end
  end

  assign dsum = DIFF_W'(err) - DIFF_W'(previous_error);
  assign dlim_s = $signed({1'b0, cfg.dlim});
  always_comb begin
    if (dsum > dlim_s) begin
      diff = dlim_s;
    end else if (dsum < -dlim_s) begin
      diff = -dlim_s;
    end else begin
      diff = dsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      error_integral <= '0;
      previous_error <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (take) begin
        error_integral <= error_integral_next;
        previous_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_data.err   <= err;
      s1_data.integ <= error_integral_next;
      s1_data.diff  <= diff;
    end
  end

endmodule

// ----- rtl/pidc_terms.sv -----
module pidc_terms (
  input  logic             clk,
  input  logic             rst,
  input  pidc_pkg::cfg_t   cfg,
  input  logic             s1_valid,
  output logic             s1_ready,
  input  pidc_pkg::front_t s1_data,
  output logic             s2_valid,
  input  logic             s2_ready,
  output pidc_pkg::terms_t s2_data
);
  import pidc_pkg::*;

  localparam int unsigned PP_W = GAIN_W + ERR_W;
  localparam int unsigned PI_W = GAIN_W + INT_W;
  localparam int unsigned PD_W = GAIN_W + DIFF_W;

  logic signed [PP_W-1:0] prod_p;
  logic signed [PI_W-1:0] prod_i;
  logic signed [PD_W-1:0] prod_d;

  assign s1_ready = !s2_valid || s2_ready;

  assign prod_p = PP_W'(cfg.kp) * PP_W'(s1_data.err);
  assign prod_i = PI_W'(cfg.ki) * PI_W'(s1_data.integ);
  assign prod_d = PD_W'(cfg.kd) * PD_W'(s1_data.diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  // drop the low 8 bits: floor of the Q8.8 product
  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2_data.tp <= prod_p[PP_W-1:8];
      s2_data.ti <= prod_i[PI_W-1:8];
      s2_data.td <= prod_d[PD_W-1:8];
    end
  end

endmodule

// ----- rtl/pidc_sum.sv -----
module pidc_sum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pidc_pkg::cfg_t                       cfg,
  input  logic                                 s2_valid,
  output logic                                 s2_ready,
  input  pidc_pkg::terms_t                     s2_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pidc_pkg::SAMPLE_W-1:0] control_output
);
  import pidc_pkg::*;

  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    olim_s;
  logic signed [SAMPLE_W-1:0] y;

  assign s2_ready = !out_valid || out_ready;

  assign sum = SUM_W'(s2_data.tp) + SUM_W'(s2_data.ti) + SUM_W'(s2_data.td);
  assign olim_s = SUM_W'($signed({1'b0, cfg.olim}));

  always_comb begin
    if (sum > olim_s) begin
      y = SAMPLE_W'(olim_s);
    end else if (sum < -olim_s) begin
      y = SAMPLE_W'(-olim_s);
    end else begin
      y = SAMPLE_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      control_output <= y;
    end
  end

endmodule

// ----- rtl/pid_controller_clamped_core.sv -----
// Clamped fixed-point PID controller. Each transfer on the input channel
// (setpoint, measured_value) yields exactly one control_output transfer, in
// order. The datapath is three register stages: error, clamped integral and
// clamped difference; the three Q8.8 gain products; the sum with output clamp
// into the output register. An input transfer reaches out_valid through the
// front, product and output registers in turn. One item is taken every cycle
// while the output is drained; a stalled output backs up one stage at a time.
// Registers (kp_gain, ki_gain, kd_gain, integral_limit, derivative_limit,
// output_limit at indexes 0 to 5) are written through cfg_we/cfg_addr/cfg_data
// and must only change while no item is in flight; writes to other indexes
// are ignored.
module pid_controller_clamped_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pidc_pkg::SAMPLE_W-1:0] setpoint,
  input  logic signed [pidc_pkg::SAMPLE_W-1:0] measured_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pidc_pkg::SAMPLE_W-1:0] control_output,
  input  logic                                 cfg_we,
  input  logic [pidc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pidc_pkg::*;

  `include "assert_macros.svh"

  cfg_t   cfg;
  logic   s1_valid;
  logic   s1_ready;
  front_t s1_data;
  logic   s2_valid;
  logic   s2_ready;
  terms_t s2_data;

  logic signed [SAMPLE_W-1:0] olim_s;
  logic                       out_in_range;

  pidc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  pidc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .setpoint       (setpoint),
    .measured_value (measured_value),
    .s1_valid       (s1_valid),
    .s1_ready       (s1_ready),
    .s1_data        (s1_data)
  );

  pidc_terms u_terms (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data)
  );

  pidc_sum u_sum (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .s2_valid       (s2_valid),
    .s2_ready       (s2_ready),
    .s2_data        (s2_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .control_output (control_output)
  );

  assign olim_s = $signed({1'b0, cfg.olim});
  assign out_in_range = (control_output <= olim_s) && (control_output >= -olim_s);

  // a draining output never blocks the input side
  `ASSERT_IMPLY(a_ready_chain, out_ready, in_ready, "input stalled while output drains")

  // the output stays within the configured clamp
  `ASSERT_IMPLY(a_out_clamp, out_valid, out_in_range, "control_output outside output_limit")

  // a new result only comes from a filled product stage
  `ASSERT_ALWAYS(a_out_source, !$rose(out_valid) || $past(s2_valid), "result without product stage")

endmodule
